// File: hw/rtl/i8rq_pkg.sv
// Shared types and register map of the int8 requantizer.
package i8rq_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_SCALE_MULT  = 3'd0;
  localparam logic [2:0] REG_SCALE_SHIFT = 3'd1;
  localparam logic [2:0] REG_OUT_ZP      = 3'd2;
  localparam logic [2:0] REG_ACT_ZP      = 3'd3;
  localparam logic [2:0] REG_WGT_ZP      = 3'd4;
  localparam logic [2:0] REG_RELU_EN     = 3'd5;
  localparam logic [2:0] REG_BIAS_EN     = 3'd6;

  localparam int unsigned CFG_IDX_W = 3;

  // Reset values
  localparam logic [30:0] SCALE_MULT_RST  = 31'd1073741824;
  localparam logic [5:0]  SCALE_SHIFT_RST = 6'd31;

  // Upper clamp of the output byte
  localparam logic signed [10:0] OUT_CEILING = 11'sd255;

  typedef struct packed {
    logic [30:0]       scale_multiplier;
    logic [5:0]        scale_shift;
    logic [7:0]        output_zero_point;
    logic [7:0]        act_zero_point;
    logic signed [7:0] weight_zero_point;
    logic              relu_enable;
    logic              bias_enable;
  } cfg_t;

endpackage

// File: hw/rtl/i8rq_zp_corr.sv
// Zero-point correction: two register stages producing the wrapped int32 raw value.
module i8rq_zp_corr (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [31:0]  accumulator,
  input  logic signed [31:0]  row_sum,
  input  logic signed [31:0]  col_sum,
  input  logic signed [31:0]  bias_value,
  input  i8rq_pkg::cfg_t      cfg,
  output logic                raw_valid,
  output logic signed [31:0]  raw
);

  // stage 1: zero-point products (low 32 bits only)
  logic               v1;
  logic [31:0]        acc1;
  logic [31:0]        bias1;
  logic [31:0]        pa1;
  logic [31:0]        pw1;

  logic [39:0]        pa_full;
  logic signed [39:0] pw_full;

  assign pa_full = 40'($unsigned(col_sum)) * 40'(cfg.act_zero_point);
  assign pw_full = 40'(row_sum) * 40'(cfg.weight_zero_point);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc1  <= $unsigned(accumulator);
      bias1 <= cfg.bias_enable ? $unsigned(bias_value) : 32'd0;
      pa1   <= pa_full[31:0];
      pw1   <= pw_full[31:0];
    end
  end

  // stage 2: wrapped sum
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_valid <= 1'b0;
    end else if (en) begin
      raw_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      raw <= $signed(acc1 - pa1 - pw1 + bias1);
    end
  end

  // valid in stage 1 passes to stage 2 whenever the pipe is enabled
  a_corr_advance: assert property (@(posedge clk) disable iff (rst)
    en && v1 |=> raw_valid)
    else $error("corrected value lost between stages");

  a_corr_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable({v1, raw_valid}))
    else $error("correction stage moved during stall");

  a_corr_entry: assert property (@(posedge clk) disable iff (rst)
    en && in_valid |=> v1)
    else $error("accepted request not captured");

endmodule

// File: hw/rtl/int8_requantize_fixed_point.sv
// Top level of the int8 requantizer: config registers and scaling pipeline.
//
//  Channel   Signals                                          Dir  Note
//  ------------------------------------------------------------------------------
//  input     in_valid/in_ready, accumulator, row_sum,          in   one request per
//            col_sum, bias_value                                     element
//  output    out_valid/out_ready, out_byte                      out  one byte per request
//  config    cfg_valid/cfg_ready, cfg_index, cfg_data           in   always ready
//
//  Throughput: one request per cycle unless stalled. Pipeline: six registers. Stages:
//  zp products, wrapped sum, 32x31 multiply, rounding nudge, shift + saturate,
//  zero point + clamp into the output register.
//  Stall: one enable moves the whole pipe; it holds only while the output register
//  is full and out_ready is low. Bubbles travel as cleared valid bits.
//  Reset: clears all valid bits and loads the config reset values.
module int8_requantize_fixed_point (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [31:0]                    accumulator,
  input  logic signed [31:0]                    row_sum,
  input  logic signed [31:0]                    col_sum,
  input  logic signed [31:0]                    bias_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [7:0]                            out_byte,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [i8rq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [31:0]                           cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers; the block takes writes any time, so the host must write only when idle
  // ---------------------------------------------------------------------------
  i8rq_pkg::cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale_multiplier  <= i8rq_pkg::SCALE_MULT_RST;
      cfg.scale_shift       <= i8rq_pkg::SCALE_SHIFT_RST;
      cfg.output_zero_point <= 8'd0;
      cfg.act_zero_point    <= 8'd0;
      cfg.weight_zero_point <= 8'sd0;
      cfg.relu_enable       <= 1'b0;
      cfg.bias_enable       <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        i8rq_pkg::REG_SCALE_MULT:  cfg.scale_multiplier  <= cfg_data[30:0];
        i8rq_pkg::REG_SCALE_SHIFT: cfg.scale_shift       <= cfg_data[5:0];
        i8rq_pkg::REG_OUT_ZP:      cfg.output_zero_point <= cfg_data[7:0];
        i8rq_pkg::REG_ACT_ZP:      cfg.act_zero_point    <= cfg_data[7:0];
        i8rq_pkg::REG_WGT_ZP:      cfg.weight_zero_point <= $signed(cfg_data[7:0]);
        i8rq_pkg::REG_RELU_EN:     cfg.relu_enable       <= cfg_data[0];
        i8rq_pkg::REG_BIAS_EN:     cfg.bias_enable       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline enable: everything moves unless a finished byte is stuck
  // ---------------------------------------------------------------------------
  logic en;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stages 1-2: zero-point correction, wraps to 32 bits
  logic               corr_valid;
  logic signed [31:0] corr_raw;

  i8rq_zp_corr u_zp_corr (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (in_valid),
    .accumulator (accumulator),
    .row_sum     (row_sum),
    .col_sum     (col_sum),
    .bias_value  (bias_value),
    .cfg         (cfg),
    .raw_valid   (corr_valid),
    .raw         (corr_raw)
  );

  // Stage 3: raw * multiplier. |prod| < 2^62, so 63 signed bits hold it.
  logic               v3;
  logic signed [62:0] prod;
  logic signed [63:0] prod_full;

  assign prod_full = 64'(corr_raw) * $signed({33'd0, cfg.scale_multiplier});

  // Stage 4: add rounding nudge 2^(sh-1); shift 0 acts as 1
  logic               v4;
  logic signed [63:0] rounded;
  logic [5:0]         sh;
  logic [63:0]        nudge;

  assign sh    = (cfg.scale_shift == 6'd0) ? 6'd1 : cfg.scale_shift;
  assign nudge = 64'd1 << (sh - 6'd1);

  // Stage 5: arithmetic shift, then saturate to [-256, 511]. Any value beyond
  // that range clamps the same way once a zero point of 0..255 is added.
  logic               v5;
  logic signed [9:0]  sat;
  logic signed [63:0] shifted;
  logic signed [9:0]  sat_next;

  assign shifted = rounded >>> sh;

  always_comb begin
    if (shifted > 64'sd511) begin
      sat_next = 10'sd511;
    end else if (shifted < -64'sd256) begin
      sat_next = -10'sd256;
    end else begin
      sat_next = shifted[9:0];
    end
  end

  // Stage 6: output zero point and clamp to [lo, 255]; this is the output register
  logic signed [10:0] val;
  logic signed [10:0] lo;
  logic [7:0]         byte_next;

  assign val = 11'(sat) + $signed({3'd0, cfg.output_zero_point});
  assign lo  = cfg.relu_enable ? $signed({3'd0, cfg.output_zero_point}) : 11'sd0;

  always_comb begin
    if (val > i8rq_pkg::OUT_CEILING) begin
      byte_next = i8rq_pkg::OUT_CEILING[7:0];
    end else if (val < lo) begin
      byte_next = lo[7:0];
    end else begin
      byte_next = val[7:0];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v3        <= corr_valid;
      v4        <= v3;
      v5        <= v4;
      out_valid <= v5;
    end
  end

  // data path
  always_ff @(posedge clk) begin
    if (en) begin
      prod     <= prod_full[62:0];
      rounded  <= 64'(prod) + $signed(nudge);
      sat      <= sat_next;
      out_byte <= byte_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable({corr_valid, v3, v4, v5}))
    else $error("pipeline valid bits moved during stall");

  a_mult_advance: assert property (@(posedge clk) disable iff (rst)
    en && corr_valid |=> v3)
    else $error("request dropped entering multiplier");

  a_out_advance: assert property (@(posedge clk) disable iff (rst)
    en && v5 |=> out_valid)
    else $error("request dropped entering output register");

  a_relu_floor: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && cfg.relu_enable && $stable(cfg) |-> out_byte >= cfg.output_zero_point)
    else $error("relu floor violated");

endmodule
